// ===== hw/rtl/sppx_pkg.sv =====
`timescale 1ns / 1ps

package sppx_pkg;

  // Framing characters
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  // Field layout
  localparam int unsigned LAST_FIELD  = 20;
  localparam logic [4:0]  FIELD_MAX   = 5'd31;
  localparam logic [4:0]  LIMIT_TYPE  = 5'd5;
  localparam logic [4:0]  LIMIT_PART  = 5'd10;
  localparam logic [4:0]  LIMIT_DEV   = 5'd16;
  localparam logic [4:0]  LIMIT_CLAMP = 5'd16;

  // Configuration register indexes
  localparam logic [1:0] REG_NAME_LIMIT  = 2'd0;
  localparam logic [1:0] REG_VALUE_LIMIT = 2'd1;

  localparam logic [4:0] NAME_LIMIT_RST  = 5'd12;
  localparam logic [4:0] VALUE_LIMIT_RST = 5'd9;

  typedef struct packed {
    logic [4:0] name_limit;
    logic [4:0] value_limit;
  } sppx_cfg_t;

  typedef struct packed {
    logic       store_en;
    logic [4:0] field_index;
    logic [3:0] char_pos;
    logic [7:0] char_value;
    logic       sentence_start;
    logic       sentence_done;
    logic       checksum_ok;
  } sppx_result_t;

  // Upper-case ASCII hex digit of a nibble
  function automatic logic [7:0] hex_of(input logic [3:0] nib);
    logic [7:0] n;
    begin
      n = {4'd0, nib};
      hex_of = (nib < 4'd10) ? (8'h30 + n) : (8'h41 + n - 8'd10);
    end
  endfunction

  // Upper-case a lower-case letter, pass everything else
  function automatic logic [7:0] upcase(input logic [7:0] c);
    begin
      upcase = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
    end
  endfunction

  function automatic logic [4:0] clamp16(input logic [4:0] v);
    begin
      clamp16 = (v > LIMIT_CLAMP) ? LIMIT_CLAMP : v;
    end
  endfunction

endpackage

// ===== hw/rtl/sppx_ifs.sv =====
`timescale 1ns / 1ps

// Input byte stream
interface sppx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, rx_byte, input ready);
  modport sink (input valid, rx_byte, output ready);
endinterface

// Result stream
interface sppx_result_if;
  logic       valid;
  logic       ready;
  logic       store_en;
  logic [4:0] field_index;
  logic [3:0] char_pos;
  logic [7:0] char_value;
  logic       sentence_start;
  logic       sentence_done;
  logic       checksum_ok;
  modport source (output valid, store_en, field_index, char_pos, char_value,
                  sentence_start, sentence_done, checksum_ok, input ready);
  modport sink (input valid, store_en, field_index, char_pos, char_value,
                sentence_start, sentence_done, checksum_ok, output ready);
endinterface

// Register write channel
interface sppx_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/sppx_cfg.sv =====
`timescale 1ns / 1ps

module sppx_cfg import sppx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sppx_cfg_if.sink   cfg,
  output sppx_cfg_t  regs
);

  // Always take register writes
  assign cfg.ready = 1'b1;

  // Write the addressed limit, drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.name_limit  <= NAME_LIMIT_RST;
      regs.value_limit <= VALUE_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_NAME_LIMIT:  regs.name_limit  <= cfg.data;
        REG_VALUE_LIMIT: regs.value_limit <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sppx_parse.sv =====
`timescale 1ns / 1ps

module sppx_parse import sppx_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  input  sppx_cfg_t    regs,
  output sppx_result_t res
);

  logic       in_sentence, in_sentence_next;
  logic       in_checksum, in_checksum_next;
  logic [1:0] digit_count, digit_count_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] recv_high_digit, recv_high_digit_next;
  logic [7:0] recv_low_digit, recv_low_digit_next;
  logic [4:0] field_counter, field_counter_next;
  logic [4:0] position_counter, position_counter_next;
  logic [4:0] limit;

  // Storage limit of the current field
  always_comb begin
    priority if (field_counter == 5'd0) limit = LIMIT_TYPE;
    else if (field_counter == 5'd1) limit = LIMIT_PART;
    else if (field_counter == 5'd2) limit = LIMIT_DEV;
    else if (field_counter > 5'(LAST_FIELD)) limit = 5'd0;
    else if (field_counter[0]) limit = clamp16(regs.name_limit);
    else limit = clamp16(regs.value_limit);
  end

  // Decode one byte against the sentence state
  always_comb begin
    in_sentence_next      = in_sentence;
    in_checksum_next      = in_checksum;
    digit_count_next      = digit_count;
    running_xor_next      = running_xor;
    recv_high_digit_next  = recv_high_digit;
    recv_low_digit_next   = recv_low_digit;
    field_counter_next    = field_counter;
    position_counter_next = position_counter;
    res                   = '0;

    priority if (rx_byte == CHAR_DOLLAR) begin
      in_sentence_next      = 1'b1;
      in_checksum_next      = 1'b0;
      digit_count_next      = 2'd0;
      running_xor_next      = 8'd0;
      field_counter_next    = 5'd0;
      position_counter_next = 5'd0;
      res.sentence_start    = 1'b1;
    end else if (!in_sentence) begin
      // ignore bytes between sentences
    end else if (in_checksum) begin
      priority if (digit_count == 2'd0) begin
        recv_high_digit_next = upcase(rx_byte);
        digit_count_next     = 2'd1;
      end else if (digit_count == 2'd1) begin
        recv_low_digit_next = upcase(rx_byte);
        digit_count_next    = 2'd2;
      end else begin
        res.sentence_done = 1'b1;
        res.checksum_ok   = (recv_high_digit == hex_of(running_xor[7:4])) &&
                            (recv_low_digit == hex_of(running_xor[3:0]));
        in_sentence_next  = 1'b0;
        in_checksum_next  = 1'b0;
        digit_count_next  = 2'd0;
      end
    end else if (rx_byte == CHAR_STAR) begin
      in_checksum_next = 1'b1;
      digit_count_next = 2'd0;
    end else begin
      if (rx_byte == CHAR_COMMA) begin
        if (field_counter != FIELD_MAX) field_counter_next = field_counter + 5'd1;
        position_counter_next = 5'd0;
      end else if (position_counter < limit) begin
        res.store_en          = 1'b1;
        res.field_index       = field_counter;
        res.char_pos          = position_counter[3:0];
        res.char_value        = rx_byte;
        position_counter_next = position_counter + 5'd1;
      end
      running_xor_next = running_xor ^ rx_byte;
    end
  end

  // Advance the sentence state once per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence      <= 1'b0;
      in_checksum      <= 1'b0;
      digit_count      <= 2'd0;
      running_xor      <= 8'd0;
      recv_high_digit  <= 8'd0;
      recv_low_digit   <= 8'd0;
      field_counter    <= 5'd0;
      position_counter <= 5'd0;
    end else if (step) begin
      in_sentence      <= in_sentence_next;
      in_checksum      <= in_checksum_next;
      digit_count      <= digit_count_next;
      running_xor      <= running_xor_next;
      recv_high_digit  <= recv_high_digit_next;
      recv_low_digit   <= recv_low_digit_next;
      field_counter    <= field_counter_next;
      position_counter <= position_counter_next;
    end
  end

endmodule

// ===== hw/rtl/sentence_parser_xor_checksum_unit.sv =====
`timescale 1ns / 1ps
// An accepted byte is held in the input register and its result beat is then registered in the result register.
// Throughput: one byte per cycle; the input register, the decode logic and the
// result register run in lockstep, so only a stalled result slows the input.
// Reset (rst, synchronous): sentence state cleared, name limit 12, value limit 9,
// both register stages empty.
module sentence_parser_xor_checksum_unit import sppx_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sppx_byte_if.sink    rx,
  sppx_result_if.source result,
  sppx_cfg_if.sink     cfg
);

  sppx_cfg_t    regs;
  sppx_result_t res;
  logic         in_valid;
  logic [7:0]   in_byte;
  logic         step;

  sppx_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Move a byte through when the result register is free or being drained
  assign step     = in_valid && (!result.valid || result.ready);
  assign rx.ready = !in_valid || step;

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  sppx_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .regs    (regs),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (step) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.store_en       <= res.store_en;
      result.field_index    <= res.field_index;
      result.char_pos       <= res.char_pos;
      result.char_value     <= res.char_value;
      result.sentence_start <= res.sentence_start;
      result.sentence_done  <= res.sentence_done;
      result.checksum_ok    <= res.checksum_ok;
    end
  end

endmodule

// ===== hw/rtl/sppx_checker.sv =====
`timescale 1ns / 1ps

module sppx_checker import sppx_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       store_en,
  input logic [4:0] field_index,
  input logic [3:0] char_pos,
  input logic [7:0] char_value,
  input logic       sentence_start,
  input logic       sentence_done,
  input logic       checksum_ok
);

  // A checksum verdict comes only with the closing beat
  a_ok_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && checksum_ok |-> sentence_done)
    else $error("checksum_ok without sentence_done");

  // A start beat carries no store and no close
  a_start_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && sentence_start |-> !store_en && !sentence_done)
    else $error("sentence_start mixed with store or done");

  // Stores land only in known fields and within the fixed limits of fields 0 and 1
  a_store_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_en |-> (field_index <= 5'(LAST_FIELD)) &&
      (field_index != 5'd0 || char_pos < 4'd5) &&
      (field_index != 5'd1 || char_pos < 4'd10))
    else $error("store outside field limits");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(store_en) &&
      $stable(field_index) && $stable(char_pos) && $stable(char_value) &&
      $stable(sentence_start) && $stable(sentence_done) && $stable(checksum_ok))
    else $error("result beat changed while stalled");

endmodule

bind sentence_parser_xor_checksum_unit sppx_checker u_sppx_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .store_en       (result.store_en),
  .field_index    (result.field_index),
  .char_pos       (result.char_pos),
  .char_value     (result.char_value),
  .sentence_start (result.sentence_start),
  .sentence_done  (result.sentence_done),
  .checksum_ok    (result.checksum_ok)
);
